FILE: rtl/drpf_pkg.sv
// Package: constants, formats and helper functions of the dead-reckoning pose fuser.
`timescale 1ns / 1ps
package drpf_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;

  localparam logic signed [35:0] PI_Q      = 36'sd843314857;
  localparam logic signed [35:0] HALF_PI_Q = 36'sd421657428;
  localparam logic signed [35:0] TWO_PI_Q  = 36'sd1686629713;
  localparam logic signed [35:0] CORDIC_K  = 36'sd652032874;
  localparam int CORDIC_STEPS = 24;

  localparam logic [63:0] MAX_AGE_RST   = 64'd10000000000;
  localparam logic [15:0] GAIN_RST      = 16'd19661;
  localparam logic [30:0] DIST_LIM_RST  = 31'd32768;
  localparam logic [30:0] YAW_LIM_RST   = 31'd402653184;

  localparam logic [1:0] REG_MAX_AGE  = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_DIST_LIM = 2'd2;
  localparam logic [1:0] REG_YAW_LIM  = 2'd3;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_ZERO   = 1'b1;

  function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0:  r = 36'sd210828714;
      5'd1:  r = 36'sd124459457;
      5'd2:  r = 36'sd65760959;
      5'd3:  r = 36'sd33381290;
      5'd4:  r = 36'sd16755422;
      5'd5:  r = 36'sd8385879;
      5'd6:  r = 36'sd4193963;
      5'd7:  r = 36'sd2097109;
      5'd8:  r = 36'sd1048571;
      5'd9:  r = 36'sd524287;
      default: r = 36'sd1 <<< (5'd28 - i);
    endcase
    return r;
  endfunction

  // one wrap step; callers chain as many passes as their input range needs
  function automatic logic signed [35:0] wrap1(input logic signed [35:0] a);
    logic signed [35:0] r;
    r = a;
    if ((r <<< 1) > TWO_PI_Q) r = r - TWO_PI_Q;
    else if ((r <<< 1) <= -TWO_PI_Q) r = r + TWO_PI_Q;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/drpf_if.sv
// Interfaces: valid/ready channels for update requests and pose results.
`timescale 1ns / 1ps
interface drpf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] time_now;
  logic signed [31:0] imu_heading;
  logic signed [31:0] odometer_reading;
  logic [63:0] obs_age;
  logic [63:0] obs_stamp;
  logic signed [31:0] obs_x;
  logic signed [31:0] obs_y;
  logic signed [31:0] obs_heading;
  modport source (output valid, cmd, time_now, imu_heading, odometer_reading, obs_age,
                  obs_stamp, obs_x, obs_y, obs_heading, input ready);
  modport sink (input valid, cmd, time_now, imu_heading, odometer_reading, obs_age,
                obs_stamp, obs_x, obs_y, obs_heading, output ready);
endinterface

interface drpf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;
  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

FILE: rtl/drpf_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle, returns cos and sin in Q1.30.
`timescale 1ns / 1ps
module drpf_cordic
  import drpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [35:0] angle,
  output logic done,
  output logic signed [35:0] cos_q,
  output logic signed [35:0] sin_q
);
  logic signed [35:0] x, y, z;
  logic [4:0] step;
  logic busy, neg;
  logic signed [35:0] zw, zw2;

  always_comb begin
    zw  = wrap1(angle);
    zw2 = wrap1(zw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_K;
        y    <= '0;
        if (zw2 > HALF_PI_Q) begin
          z <= zw2 - PI_Q; neg <= 1'b1;
        end else if (zw2 < -HALF_PI_Q) begin
          z <= zw2 + PI_Q; neg <= 1'b1;
        end else begin
          z <= zw2; neg <= 1'b0;
        end
      end else if (busy) begin
        if (!z[35]) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - atan_entry(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + atan_entry(step);
        end
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign cos_q = neg ? -x : x;
  assign sin_q = neg ? -y : y;
endmodule

FILE: rtl/dead_reckoning_pose_fuser_unit.sv
// Top level: pose history ring, search, replay sequencer and APB registers.
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cmd, time, imu, odometer, observation
//  res     | out | valid/ready   | pose_x, pose_y, pose_heading
//  apb     | in  | psel/penable  | four configuration registers
// A pose step reads the previous and current entries, prepares, runs the CORDIC (start plus
// 24 rotations plus done), then forms products, blends and writes back. The search reads
// and checks one entry at a time. Worst update: 64 steps and 63 searched entries.
// A zero command sweeps the ring.
// After reset a clearing pass over the ring runs before the first request.
// The request side is not ready until the result register has been taken.
`timescale 1ns / 1ps
module dead_reckoning_pose_fuser_unit
  import drpf_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  drpf_in_if.sink    req,
  drpf_out_if.source res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ZERO = 4'd2, S_PUSH = 4'd3,
                         S_RD_P = 4'd4, S_RD_Q = 4'd5, S_PREP = 4'd6, S_CORD = 4'd7,
                         S_MUL = 4'd8, S_BLEND = 4'd9, S_WB = 4'd10, S_SRCH = 4'd11,
                         S_SRCH_CHK = 4'd12, S_OUT_RD = 4'd13, S_OUT = 4'd14;

  // registers
  logic [63:0] max_age;
  logic [15:0] gain;
  logic [30:0] dist_lim, yaw_lim;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RST; gain <= GAIN_RST;
      dist_lim <= DIST_LIM_RST; yaw_lim <= YAW_LIM_RST;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (paddr[4:3])
        REG_MAX_AGE:  max_age <= pwdata;
        REG_GAIN:     gain <= pwdata[15:0];
        REG_DIST_LIM: dist_lim <= pwdata[30:0];
        REG_YAW_LIM:  yaw_lim <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:3])
      REG_MAX_AGE:  prdata = max_age;
      REG_GAIN:     prdata = {48'd0, gain};
      REG_DIST_LIM: prdata = {33'd0, dist_lim};
      REG_YAW_LIM:  prdata = {33'd0, yaw_lim};
      default:      prdata = '0;
    endcase
  end

  // ring memories: sample (time, imu, odo), pose, observation
  logic [63:0]  m_time [HISTORY_DEPTH];
  logic [63:0]  m_samp [HISTORY_DEPTH];
  logic [95:0]  m_pose [HISTORY_DEPTH];
  logic [96:0]  m_obs  [HISTORY_DEPTH];

  logic [3:0] state;
  logic [AW-1:0] newest, cnt, q_slot, rd_a;
  logic [AW:0] idx;  // logical index of q during replay
  logic replay;
  logic [63:0] r_stamp, r_time;
  logic signed [31:0] r_ox, r_oy, r_oh, r_imu, r_odo;
  logic [63:0] rd_time, rd_samp;
  logic [95:0] rd_pose;
  logic [96:0] rd_obs;
  logic signed [31:0] p_imu, p_odo, p_x, p_y, p_h;
  logic signed [35:0] ds, yaw, px, py, cs, sn, nx, ny;
  logic signed [67:0] prod_x, prod_y;
  logic cs_start, cs_done;
  logic signed [35:0] cs_c, cs_s;
  logic mw_en;
  logic [AW-1:0] mw_a;
  logic [95:0] mw_pose;
  logic signed [31:0] out_x, out_y, out_h;
  logic out_v;

  drpf_cordic u_cordic (.clk, .rst, .start(cs_start), .angle(yaw), .done(cs_done),
                        .cos_q(cs_c), .sin_q(cs_s));

  always_ff @(posedge clk) begin
    rd_time <= m_time[rd_a];
    rd_samp <= m_samp[rd_a];
    rd_pose <= m_pose[rd_a];
    rd_obs  <= m_obs[rd_a];
    if (mw_en) m_pose[mw_a] <= mw_pose;
    if (state == S_CLEAR) begin
      m_time[cnt] <= '0; m_samp[cnt] <= '0; m_obs[cnt] <= '0;
    end else if (state == S_PUSH) begin
      m_time[newest] <= r_time;
      m_samp[newest] <= {r_imu, r_odo};
      m_obs[newest]  <= '0;
    end else if (state == S_SRCH_CHK && rd_time == r_stamp && !rd_obs[96] && idx != '0) begin
      m_obs[rd_a] <= {1'b1, r_ox, r_oy, r_oh};
    end
  end

  // blend arithmetic for the step in flight
  logic signed [35:0] ex, ey, eh, dy;
  logic signed [35:0] imu_d, odo_d;
  logic signed [35:0] yl_s, dl_s;
  logic signed [52:0] gx, gy, gh;
  always_comb begin
    yl_s  = signed'(36'(yaw_lim));
    dl_s  = signed'(36'(dist_lim));
    odo_d = 36'(signed'(rd_samp[31:0] - p_odo));
    // raw difference spans up to about 16 rad, so three passes
    imu_d = wrap1(wrap1(wrap1(36'(signed'(rd_samp[63:32])) - 36'(p_imu))));
    dy    = (imu_d > -yl_s && imu_d < yl_s) ? imu_d : '0;
    ex = 36'(signed'(rd_obs[95:64])) - nx;
    ey = 36'(signed'(rd_obs[63:32])) - ny;
    eh = wrap1(wrap1(36'(signed'(rd_obs[31:0])) - yaw));
    gx = 53'(signed'({1'b0, gain})) * 53'(ex) + 53'sd32768;
    gy = 53'(signed'({1'b0, gain})) * 53'(ey) + 53'sd32768;
    gh = 53'(signed'({1'b0, gain})) * 53'(eh) + 53'sd32768;
  end

  logic signed [35:0] fx, fy, fh, fh_w;
  always_comb begin
    if (rd_obs[96]) begin
      fx = nx + 36'(gx >>> 16); fy = ny + 36'(gy >>> 16); fh = yaw + 36'(gh >>> 16);
    end else begin
      fx = nx; fy = ny; fh = yaw;
    end
  end

  // pose write port: clearing, zero sweep and step write-back share this one port
  always_comb begin
    fh_w    = wrap1(wrap1(fh));
    mw_en   = 1'b0;
    mw_a    = cnt;
    mw_pose = '0;
    case (state)
      S_CLEAR, S_ZERO: mw_en = 1'b1;
      S_WB: begin
        mw_en   = 1'b1;
        mw_a    = q_slot;
        mw_pose = {sat32(fx), sat32(fy), fh_w[31:0]};
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE) && !out_v;

  always_ff @(posedge clk) begin
    cs_start <= !rst && state == S_PREP;
    if (rst) begin
      state <= S_CLEAR; cnt <= '0; newest <= '0; out_v <= 1'b0;
    end else begin
      if (out_v && res.ready) out_v <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          r_stamp <= req.obs_stamp; r_ox <= req.obs_x; r_oy <= req.obs_y;
          r_oh <= req.obs_heading;
          r_time <= req.time_now; r_imu <= req.imu_heading;
          r_odo <= req.odometer_reading;
          replay <= req.obs_age < max_age;
          cnt <= '0;
          if (req.cmd == CMD_ZERO) state <= S_ZERO;
          else begin
            newest <= (newest == LAST) ? '0 : newest + 1'b1;
            state <= S_PUSH;
          end
        end
        S_ZERO: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            rd_a <= newest; state <= S_OUT_RD;
          end
        end
        S_PUSH: begin
          q_slot <= newest;
          rd_a   <= (newest == '0) ? LAST : newest - 1'b1;
          idx <= '0;
          state <= S_RD_P;
        end
        S_RD_P: begin rd_a <= q_slot; state <= S_RD_Q; end
        S_RD_Q: begin
          p_imu <= rd_samp[63:32]; p_odo <= rd_samp[31:0];
          p_x <= rd_pose[95:64]; p_y <= rd_pose[63:32]; p_h <= rd_pose[31:0];
          state <= S_PREP;
        end
        S_PREP: begin
          // rd_* hold q now
          ds  <= (odo_d > -dl_s && odo_d < dl_s) ? odo_d : '0;
          yaw <= 36'(p_h) + dy;
          px <= 36'(p_x); py <= 36'(p_y);
          state <= S_CORD;
        end
        S_CORD: if (cs_done) begin
          cs <= cs_c; sn <= cs_s; state <= S_MUL;
        end
        S_MUL: begin
          prod_x <= 68'(ds) * 68'(cs) + (68'sd1 <<< 29);
          prod_y <= 68'(ds) * 68'(sn) + (68'sd1 <<< 29);
          state <= S_BLEND;
        end
        S_BLEND: begin
          nx <= px + 36'(prod_x >>> 30);
          ny <= py + 36'(prod_y >>> 30);
          state <= S_WB;
        end
        S_WB: begin
          if (idx == '0) begin
            if (replay) begin
              // search logical HISTORY_DEPTH-1 down to 1 (newest first)
              idx <= (AW+1)'(HISTORY_DEPTH - 1);
              rd_a <= newest; cnt <= newest;
              state <= S_SRCH;
            end else begin
              rd_a <= newest; state <= S_OUT_RD;
            end
          end else if (idx == (AW+1)'(HISTORY_DEPTH - 1)) begin
            rd_a <= newest; state <= S_OUT_RD;
          end else begin
            idx <= idx + 1'b1;
            q_slot <= (q_slot == LAST) ? '0 : q_slot + 1'b1;
            rd_a <= q_slot;
            state <= S_RD_P;
          end
        end
        S_SRCH: state <= S_SRCH_CHK;  // read latency
        S_SRCH_CHK: begin
          if (idx == '0) begin
            rd_a <= newest; state <= S_OUT_RD;
          end else if (rd_time == r_stamp) begin
            if (rd_obs[96]) begin
              rd_a <= newest; state <= S_OUT_RD;
            end else begin
              // replay from this entry to the newest
              q_slot <= rd_a;
              rd_a   <= (rd_a == '0) ? LAST : rd_a - 1'b1;
              state <= S_RD_P;
            end
          end else begin
            idx <= idx - 1'b1;
            rd_a <= (rd_a == '0) ? LAST : rd_a - 1'b1;
            state <= S_SRCH;
          end
        end
        S_OUT_RD: state <= S_OUT;
        S_OUT: begin
          out_x <= rd_pose[95:64]; out_y <= rd_pose[63:32]; out_h <= rd_pose[31:0];
          out_v <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = out_v;
  assign res.pose_x = out_x;
  assign res.pose_y = out_y;
  assign res.pose_heading = out_h;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !res.ready |=> out_v && $stable(out_x))
    else $error("result changed while stalled");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("ready while busy");
  a_cord: assert property (@(posedge clk) disable iff (rst)
    cs_done |-> state == S_CORD)
    else $error("stray cordic done");
endmodule

FILE: sim/drpf_pose_checker.sv
// Checker: predicts the pose for every accepted request and compares the results.
`timescale 1ns / 1ps
module drpf_pose_checker
  import drpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  drpf_in_if          rq,
  drpf_out_if         rs,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = 64;
  localparam longint PI_V = 64'sd843314857;
  localparam longint HALF_PI_V = 64'sd421657428;
  localparam longint TWO_PI_V = 64'sd1686629713;
  localparam longint GAIN_K = 64'sd652032874;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
  } pose_t;

  pose_t pose_q[$];

  logic [63:0] age_limit;
  logic [15:0] gain;
  logic [30:0] dist_lim;
  logic [30:0] yaw_lim;

  logic [63:0] t_mem [DEPTH];
  int          imu_mem [DEPTH];
  int          odo_mem [DEPTH];
  int          px_mem [DEPTH];
  int          py_mem [DEPTH];
  int          ph_mem [DEPTH];
  bit          has_obs [DEPTH];
  int          ox_mem [DEPTH];
  int          oy_mem [DEPTH];
  int          oh_mem [DEPTH];
  int          newest;

  assign pending = pose_q.size();

  function automatic longint wrap_yaw(longint a);
    longint r;
    r = a;
    while (2 * r > TWO_PI_V) r -= TWO_PI_V;
    while (2 * r <= -TWO_PI_V) r += TWO_PI_V;
    return r;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint atan_val(int i);
    longint tab [10] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                         4193963, 2097109, 1048571, 524287};
    if (i < 10) return tab[i];
    return 64'sd1 <<< (28 - i);
  endfunction

  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = wrap_yaw(ang);
    x = GAIN_K;
    y = 0;
    flip = 0;
    if (z > HALF_PI_V) begin
      z -= PI_V;
      flip = 1;
    end else if (z < -HALF_PI_V) begin
      z += PI_V;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_val(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_val(i);
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic int ring_slot(int l);
    return (newest + 1 + l) % DEPTH;
  endfunction

  task automatic advance_pose(int p, int q);
    logic [31:0] dodo;
    longint ds, dyaw, yaw, x, y, c, s, ex, ey, eh;
    dodo = odo_mem[q] - odo_mem[p];
    ds = longint'(signed'(dodo));
    dyaw = wrap_yaw(longint'(imu_mem[q]) - longint'(imu_mem[p]));
    if (!(ds > -longint'(dist_lim) && ds < longint'(dist_lim))) ds = 0;
    if (!(dyaw > -longint'(yaw_lim) && dyaw < longint'(yaw_lim))) dyaw = 0;
    yaw = longint'(ph_mem[p]) + dyaw;
    sin_cos(yaw, c, s);
    x = longint'(px_mem[p]) + rnd_shift(ds * c, 30);
    y = longint'(py_mem[p]) + rnd_shift(ds * s, 30);
    if (has_obs[q]) begin
      ex = longint'(ox_mem[q]) - x;
      ey = longint'(oy_mem[q]) - y;
      eh = wrap_yaw(longint'(oh_mem[q]) - yaw);
      x += rnd_shift(longint'(gain) * ex, 16);
      y += rnd_shift(longint'(gain) * ey, 16);
      yaw += rnd_shift(longint'(gain) * eh, 16);
    end
    px_mem[q] = clip32(x);
    py_mem[q] = clip32(y);
    ph_mem[q] = int'(wrap_yaw(yaw));
  endtask

  task automatic fuse_request();
    int n, k, start;
    pose_t pr;
    if (rq.cmd == CMD_ZERO) begin
      for (int i = 0; i < DEPTH; i++) begin
        px_mem[i] = 0;
        py_mem[i] = 0;
        ph_mem[i] = 0;
      end
    end else begin
      newest = (newest + 1) % DEPTH;
      n = newest;
      t_mem[n] = rq.time_now;
      imu_mem[n] = rq.imu_heading;
      odo_mem[n] = rq.odometer_reading;
      has_obs[n] = 0;
      ox_mem[n] = 0;
      oy_mem[n] = 0;
      oh_mem[n] = 0;
      advance_pose(ring_slot(DEPTH - 2), ring_slot(DEPTH - 1));
      if (rq.obs_age < age_limit) begin
        start = 0;
        for (int i = DEPTH - 1; i > 0; i--) begin
          k = ring_slot(i);
          if (t_mem[k] == rq.obs_stamp) begin
            if (!has_obs[k]) begin
              has_obs[k] = 1;
              ox_mem[k] = rq.obs_x;
              oy_mem[k] = rq.obs_y;
              oh_mem[k] = rq.obs_heading;
              start = i;
            end
            break;
          end
        end
        // replay from the newly observed entry up to the newest
        if (start > 0)
          for (int i = start; i < DEPTH; i++) advance_pose(ring_slot(i - 1), ring_slot(i));
      end
    end
    pr.x = px_mem[newest];
    pr.y = py_mem[newest];
    pr.h = ph_mem[newest];
    pose_q.push_back(pr);
  endtask

  always @(posedge clk) begin
    pose_t e;
    int nerr;
    if (rst) begin
      age_limit <= MAX_AGE_RST;
      gain <= GAIN_RST;
      dist_lim <= DIST_LIM_RST;
      yaw_lim <= YAW_LIM_RST;
      newest = 0;
      for (int i = 0; i < DEPTH; i++) begin
        t_mem[i] = '0; imu_mem[i] = 0; odo_mem[i] = 0;
        px_mem[i] = 0; py_mem[i] = 0; ph_mem[i] = 0;
        has_obs[i] = 0; ox_mem[i] = 0; oy_mem[i] = 0; oh_mem[i] = 0;
      end
      pose_q.delete();
      fail_count <= 0;
    end else begin
      nerr = 0;
      if (rs.valid && rs.ready) begin
        if (pose_q.size() == 0) begin
          $error("pose result with no request outstanding");
          nerr++;
        end else begin
          e = pose_q.pop_front();
          if (rs.pose_x !== e.x) begin
            $error("pose_x expected %0d actual %0d", e.x, rs.pose_x);
            nerr++;
          end
          if (rs.pose_y !== e.y) begin
            $error("pose_y expected %0d actual %0d", e.y, rs.pose_y);
            nerr++;
          end
          if (rs.pose_heading !== e.h) begin
            $error("pose_heading expected %0d actual %0d", e.h, rs.pose_heading);
            nerr++;
          end
        end
      end
      fail_count <= fail_count + nerr;
      if (rq.valid && rq.ready) fuse_request();
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
        case (paddr[4:3])
          REG_MAX_AGE:  age_limit <= pwdata;
          REG_GAIN:     gain <= pwdata[15:0];
          REG_DIST_LIM: dist_lim <= pwdata[30:0];
          REG_YAW_LIM:  yaw_lim <= pwdata[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sim/dead_reckoning_pose_fuser_unit_test.sv
// Testbench top: request stimulus, register phases, result back-pressure and verdict.
`timescale 1ns / 1ps
module dead_reckoning_pose_fuser_unit_test;
  import drpf_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic        cmd;
    logic [63:0] t;
    logic [31:0] imu;
    logic [31:0] odo;
    logic [63:0] age;
    logic [63:0] stamp;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oh;
  } upd_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int fails, pending;
  bit quiet = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  logic [63:0] t_now = 64'd1000;
  logic [31:0] imu_now = '0, odo_now = '0;
  logic [63:0] recent_t [$];

  drpf_in_if rq_if();
  drpf_out_if rs_if();

  dead_reckoning_pose_fuser_unit i_dut (
    .clk(clk), .rst(rst), .req(rq_if.sink), .res(rs_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drpf_pose_checker i_chk (
    .clk(clk), .rst(rst), .rq(rq_if), .rs(rs_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fails), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    rq_if.valid = 0; rq_if.cmd = CMD_UPDATE; rq_if.time_now = '0;
    rq_if.imu_heading = '0; rq_if.odometer_reading = '0; rq_if.obs_age = '0;
    rq_if.obs_stamp = '0; rq_if.obs_x = '0; rq_if.obs_y = '0; rq_if.obs_heading = '0;
    rs_if.ready = 0;
  end

  // result back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rs_if.ready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      rs_if.ready <= 0;
    end else begin
      rs_if.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((rq_if.valid && rq_if.ready) || (rs_if.valid && rs_if.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send(input upd_t u);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      rq_if.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    rq_if.valid <= 1;
    rq_if.cmd <= u.cmd; rq_if.time_now <= u.t; rq_if.imu_heading <= u.imu;
    rq_if.odometer_reading <= u.odo; rq_if.obs_age <= u.age; rq_if.obs_stamp <= u.stamp;
    rq_if.obs_x <= u.ox; rq_if.obs_y <= u.oy; rq_if.obs_heading <= u.oh;
    do @(posedge clk); while (!rq_if.ready);
    if (u.cmd == CMD_UPDATE) begin
      recent_t.push_back(u.t);
      if (recent_t.size() > 70) void'(recent_t.pop_front());
    end
  endtask

  function automatic upd_t mk(logic cmd, logic [63:0] t, logic [31:0] imu, logic [31:0] odo,
                              logic [63:0] age, logic [63:0] stamp, logic [31:0] ox,
                              logic [31:0] oy, logic [31:0] oh);
    upd_t u;
    u.cmd = cmd; u.t = t; u.imu = imu; u.odo = odo; u.age = age; u.stamp = stamp;
    u.ox = ox; u.oy = oy; u.oh = oh;
    return u;
  endfunction

  // mostly plausible vehicle motion with delayed observations of past samples
  task automatic random_update();
    upd_t u;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      u = mk(CMD_ZERO, {$urandom, $urandom}, $urandom, $urandom, {$urandom, $urandom},
             {$urandom, $urandom}, $urandom, $urandom, $urandom);
    end else if (r < 18) begin
      u = mk(CMD_UPDATE, {$urandom, $urandom}, $urandom, $urandom, {$urandom, $urandom},
             {$urandom, $urandom}, $urandom, $urandom, $urandom);
    end else begin
      t_now = t_now + $urandom_range(1, 20000000);
      imu_now = imu_now + ($urandom_range(0, 9) == 0 ? $urandom
                           : $urandom_range(0, 60000000) - 30000000);
      odo_now = odo_now + ($urandom_range(0, 9) == 0 ? $urandom
                           : $urandom_range(0, 40000) - 20000);
      u = mk(CMD_UPDATE, t_now, imu_now, odo_now, $urandom_range(0, 50000000), '0,
             $urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
             $urandom_range(0, 1686629713) - 843314856);
      if (recent_t.size() > 0 && $urandom_range(0, 9) < 8)
        u.stamp = recent_t[$urandom_range(0, recent_t.size() - 1)];
      else
        u.stamp = t_now + $urandom_range(1, 100);
      if ($urandom_range(0, 19) == 0) u.age = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) begin
        u.ox = $urandom;
        u.oy = $urandom;
      end
      t_now = u.t;
    end
    send(u);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed part under reset register values
    send(mk(CMD_UPDATE, 64'd0, 32'sh0, 32'sh0, 64'd0, 64'd0, 32'sh10000, 32'sh0, 32'sh0));
    send(mk(CMD_UPDATE, 64'd100, 32'sh7fffffff, 32'sh7fff, 64'd5, 64'd100,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send(mk(CMD_UPDATE, 64'd200, 32'sh80000000, 32'sh80000000, 64'd5, 64'd100,
            32'sh0, 32'sh0, 32'sh0));
    send(mk(CMD_UPDATE, 64'd300, 32'sh0, 32'sh4000, 64'd9999999999, 64'd200,
            32'sh80000000, 32'sh80000000, 32'sh80000000));
    send(mk(CMD_UPDATE, 64'd400, 32'sh17ffffff, 32'sh8000, 64'd10000000000, 64'd300,
            32'sh50000, 32'sh50000, 32'sh0));
    send(mk(CMD_UPDATE, 64'd500, 32'sh2fffffff, 32'sh7fff, 64'hffffffffffffffff, 64'd400,
            32'sh0, 32'sh0, 32'sh0));
    send(mk(CMD_UPDATE, 64'd600, 32'sh2fffffff, 32'sh10000, 64'd0, 64'd12345,
            32'sh0, 32'sh0, 32'sh0));
    send(mk(CMD_UPDATE, 64'd700, 32'sh3fffffff, 32'sh14000, 64'd0, 64'd600,
            32'sh0, 32'sh0, -32'sd843314857));
    send(mk(CMD_UPDATE, 64'd800, 32'sh4fffffff, 32'sh18000, 64'd0, 64'd700,
            32'sh7fff0000, 32'sh80010000, 32'sh32400000));
    send(mk(CMD_ZERO, 64'hffffffffffffffff, 32'shffffffff, 32'shffffffff, 64'd0,
            64'd800, 32'sh1, 32'sh1, 32'sh1));
    send(mk(CMD_UPDATE, 64'hffffffffffffffff, -32'sd843314857, 32'sh1c000, 64'd1,
            64'hffffffffffffffff, 32'sh12345, -32'sd54321, 32'sd843314857));
    send(mk(CMD_UPDATE, 64'd900, 32'sd843314857, 32'sh20000, 64'd1, 64'd800,
            32'sh0, 32'sh0, 32'sh0));
    for (int i = 0; i < 12; i++) random_update();
    rq_if.valid <= 0;
    drain();

    // widest limits and full gain
    reg_write(REG_MAX_AGE, 64'hffffffffffffffff);
    reg_write(REG_GAIN, 64'd65535);
    reg_write(REG_DIST_LIM, 64'h7fffffff);
    reg_write(REG_YAW_LIM, 64'h7fffffff);
    for (int i = 0; i < 25; i++) random_update();
    rq_if.valid <= 0;
    drain();

    // everything closed: observations ignored, steps dropped
    reg_write(REG_MAX_AGE, 64'd0);
    reg_write(REG_GAIN, 64'd0);
    reg_write(REG_DIST_LIM, 64'd0);
    reg_write(REG_YAW_LIM, 64'd0);
    for (int i = 0; i < 20; i++) random_update();
    rq_if.valid <= 0;
    drain();

    reg_write(REG_MAX_AGE, {$urandom, $urandom});
    reg_write(REG_GAIN, $urandom_range(0, 65535));
    reg_write(REG_DIST_LIM, $urandom_range(1000, 200000));
    reg_write(REG_YAW_LIM, $urandom_range(10000000, 900000000));
    for (int i = 0; i < 25; i++) random_update();
    rq_if.valid <= 0;
    drain();

    reg_write(REG_MAX_AGE, MAX_AGE_RST);
    reg_write(REG_GAIN, 64'd1);
    reg_write(REG_DIST_LIM, DIST_LIM_RST);
    reg_write(REG_YAW_LIM, YAW_LIM_RST);
    for (int i = 0; i < 15; i++) random_update();
    quiet = 1;
    for (int i = 0; i < 20; i++) random_update();
    rq_if.valid <= 0;
    drain();
    repeat (100) @(posedge clk);

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
